// File: hdl/prja_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// prja_pkg: shared types and constants for the promo revenue join/aggregate
// Field widths, register codes, item/result records, reset values.
// -----------------------------------------------------------------------------
package prja_pkg;

	// payload widths
	localparam int unsigned KEY_IN_W  = 18;
	localparam int unsigned PREFIX_W  = 40;
	localparam int unsigned TEXT_W    = 64;
	localparam int unsigned PRICE_W   = 24;
	localparam int unsigned DISC_W    = 7;
	localparam int unsigned SUM_W     = 56;
	localparam int unsigned AMT_W     = 31;   // 24-bit price times at most 100

	// configuration
	localparam int unsigned YEAR_W     = 14;
	localparam int unsigned MONTH_W    = 4;
	localparam int unsigned DAY_W      = 5;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 14;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_YEAR  = 2'd0,
		REG_START_MONTH = 2'd1,
		REG_START_DAY   = 2'd2
	} cfg_reg_t;

	localparam logic [YEAR_W-1:0]  START_YEAR_RST  = 14'd1995;
	localparam logic [MONTH_W-1:0] START_MONTH_RST = 4'd9;
	localparam logic [DAY_W-1:0]   START_DAY_RST   = 5'd1;

	// record kinds
	localparam logic KIND_PART = 1'b0;
	localparam logic KIND_LINE = 1'b1;

	// "PROMO" in ASCII, first byte most significant
	localparam logic [PREFIX_W-1:0] PROMO_TAG = 40'h50524F4D4F;

	// default sizes
	localparam int unsigned KEY_BITS_DEF  = 18;
	localparam int unsigned MID_DEPTH_DEF = 4;
	localparam int unsigned OUT_DEPTH_DEF = 4;

	// classified record, front to back
	typedef struct packed {
		logic             kind;
		logic             key_ok;
		logic             promo;
		logic             win_ok;   // date parsed and inside window
		logic [AMT_W-1:0] amount;
	} item_t;

	// result record
	typedef struct packed {
		logic [SUM_W-1:0] total;
		logic [SUM_W-1:0] promo;
		logic             hit;
	} res_t;

endpackage
`default_nettype wire

// File: hdl/prja_queue.sv
`default_nettype none
// -----------------------------------------------------------------------------
// prja_queue: small synchronous FIFO
// Register-array FIFO with occupancy count; head is shown combinationally.
// -----------------------------------------------------------------------------
module prja_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = prja_pkg::MID_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire logic [WIDTH-1:0]             wdata,
	input  wire logic                         pop,
	output logic      [WIDTH-1:0]             rdata,
	output logic                              empty,
	output logic                              full,
	output logic      [$clog2(DEPTH+1)-1:0]   count
);
	import prja_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH-1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/prja_front.sv
`default_nettype none
// -----------------------------------------------------------------------------
// prja_front: config registers and record classification
// Parses the ASCII ship date, checks the window, forms amount and promo tag.
// -----------------------------------------------------------------------------
module prja_front #(
	parameter int unsigned KEY_BITS = prja_pkg::KEY_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [prja_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [prja_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               kind,
	input  wire logic [prja_pkg::KEY_IN_W-1:0]      part_key,
	input  wire logic [prja_pkg::PREFIX_W-1:0]      type_prefix,
	input  wire logic [prja_pkg::TEXT_W-1:0]        ship_date_text,
	input  wire logic [prja_pkg::PRICE_W-1:0]       price_cents,
	input  wire logic [prja_pkg::DISC_W-1:0]        discount_pct,
	output prja_pkg::item_t                         item,
	output logic      [KEY_BITS-1:0]                idx
);
	import prja_pkg::*;

	localparam int unsigned KW = (KEY_BITS > KEY_IN_W) ? KEY_BITS : KEY_IN_W;

	logic [YEAR_W-1:0]  start_year_q;
	logic [MONTH_W-1:0] start_month_q;
	logic [DAY_W-1:0]   start_day_q;

	logic [7:0]         chr   [8];
	logic [3:0]         dig   [8];
	logic [7:0]         is_dig;
	logic [YEAR_W-1:0]  s_year;
	logic [6:0]         s_month, s_day;
	logic [YEAR_W:0]    lo_year, hi_year;
	logic [6:0]         lo_month, hi_month, lo_day;
	logic               ge_lo, lt_hi;
	logic [DISC_W-1:0]  disc_eff, mult;
	logic [KW-1:0]      key_ext;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_year_q  <= START_YEAR_RST;
			start_month_q <= START_MONTH_RST;
			start_day_q   <= START_DAY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_START_YEAR:  start_year_q  <= cfg_data[YEAR_W-1:0];
				REG_START_MONTH: start_month_q <= cfg_data[MONTH_W-1:0];
				REG_START_DAY:   start_day_q   <= cfg_data[DAY_W-1:0];
				default: ;  // unmapped index, ignored
			endcase
		end
	end

	// character 0 is the most significant byte
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			chr[i]    = ship_date_text[TEXT_W-1-8*i -: 8];
			dig[i]    = chr[i][3:0];
			is_dig[i] = (chr[i] >= 8'h30) && (chr[i] <= 8'h39);
		end
	end

	assign s_year  = YEAR_W'(dig[0]) * YEAR_W'(1000) + YEAR_W'(dig[1]) * YEAR_W'(100)
	               + YEAR_W'(dig[2]) * YEAR_W'(10)   + YEAR_W'(dig[3]);
	assign s_month = 7'(dig[4]) * 7'd10 + 7'(dig[5]);
	assign s_day   = 7'(dig[6]) * 7'd10 + 7'(dig[7]);

	// window end: next month, December wraps to January of next year
	always_comb begin
		lo_year  = (YEAR_W+1)'(start_year_q);
		lo_month = 7'(start_month_q);
		lo_day   = 7'(start_day_q);
		if (start_month_q == 4'd12) begin
			hi_year  = lo_year + 1'b1;
			hi_month = 7'd1;
		end else begin
			hi_year  = lo_year;
			hi_month = lo_month + 1'b1;
		end
	end

	// dates compare as (year, month, day) tuples
	assign ge_lo = ((YEAR_W+1)'(s_year) > lo_year) ||
	               (((YEAR_W+1)'(s_year) == lo_year) &&
	                ((s_month > lo_month) || ((s_month == lo_month) && (s_day >= lo_day))));
	assign lt_hi = ((YEAR_W+1)'(s_year) < hi_year) ||
	               (((YEAR_W+1)'(s_year) == hi_year) &&
	                ((s_month < hi_month) || ((s_month == hi_month) && (s_day < lo_day))));

	assign disc_eff = (discount_pct > 7'd100) ? 7'd100 : discount_pct;
	assign mult     = 7'd100 - disc_eff;

	assign key_ext  = KW'(part_key);
	assign idx      = key_ext[KEY_BITS-1:0];

	always_comb begin
		item.kind   = kind;
		item.key_ok = ((key_ext >> KEY_BITS) == '0);
		item.promo  = (type_prefix == PROMO_TAG);
		item.win_ok = (&is_dig) & ge_lo & lt_hi;
		item.amount = AMT_W'(price_cents) * AMT_W'(mult);
	end

endmodule
`default_nettype wire

// File: hdl/prja_back.sv
`default_nettype none
// -----------------------------------------------------------------------------
// prja_back: part table and saturating accumulators
// Table read, forward of last write, build update or probe accumulate.
// -----------------------------------------------------------------------------
module prja_back #(
	parameter int unsigned KEY_BITS  = prja_pkg::KEY_BITS_DEF,
	parameter int unsigned OUT_DEPTH = prja_pkg::OUT_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	input  wire prja_pkg::item_t                  item,
	input  wire logic [KEY_BITS-1:0]              idx,
	output logic                                  item_pop,
	input  wire logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
	output logic                                  res_valid,
	output prja_pkg::res_t                        res,
	output logic                                  clearing
);
	import prja_pkg::*;

	localparam int unsigned DEPTH   = 1 << KEY_BITS;
	localparam int unsigned CNT_W   = $clog2(OUT_DEPTH+1);
	localparam int unsigned E_VALID = 0;
	localparam int unsigned E_PROMO = 1;

	logic [1:0]          table_q [DEPTH];
	logic                clr_active_q;
	logic [KEY_BITS-1:0] clr_idx_q;

	logic                valid_s1;
	item_t               item_s1;
	logic [KEY_BITS-1:0] idx_s1;
	logic [1:0]          rd_data_s1;

	logic                fwd_valid_q;
	logic [KEY_BITS-1:0] fwd_idx_q;
	logic [1:0]          fwd_data_q;

	logic [SUM_W-1:0]    total_q, promo_q, total_nxt, promo_nxt;
	logic [CNT_W:0]      inflight;
	logic [1:0]          entry, bld_data;
	logic                bld_wr, hit, count_it;
	logic                wr_en;
	logic [KEY_BITS-1:0] wr_idx;
	logic [1:0]          wr_data;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
	                                             input logic [AMT_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W+1)'(b);
		sat_add = s[SUM_W] ? '1 : s[SUM_W-1:0];
	endfunction

	assign clearing = clr_active_q;

	// credit: only issue when the result queue can take every item in flight
	assign inflight = (CNT_W+1)'(out_count) + (CNT_W+1)'(valid_s1);
	assign item_pop = item_valid & ~clr_active_q & (inflight < (CNT_W+1)'(OUT_DEPTH));

	// read the entry in the same cycle the head leaves the queue
	always_ff @(posedge clk) begin
		if (item_pop) begin
			rd_data_s1 <= table_q[idx];
			item_s1    <= item;
			idx_s1     <= idx;
		end
	end

	// the read above misses a write landing on the same edge
	assign entry = (fwd_valid_q && (fwd_idx_q == idx_s1)) ? fwd_data_q : rd_data_s1;

	always_comb begin
		bld_data           = '0;
		bld_data[E_VALID]  = 1'b1;
		bld_data[E_PROMO]  = item_s1.promo;
		bld_wr             = valid_s1 && (item_s1.kind == KIND_PART)
		                     && item_s1.key_ok && !entry[E_VALID];
		count_it           = valid_s1 && (item_s1.kind == KIND_LINE) && item_s1.win_ok
		                     && item_s1.key_ok && entry[E_VALID];
		hit                = bld_wr | count_it;
		total_nxt          = count_it ? sat_add(total_q, item_s1.amount) : total_q;
		promo_nxt          = (count_it && entry[E_PROMO]) ?
		                     sat_add(promo_q, item_s1.amount) : promo_q;
	end

	assign wr_en   = clr_active_q | bld_wr;
	assign wr_idx  = clr_active_q ? clr_idx_q : idx_s1;
	assign wr_data = clr_active_q ? 2'b00 : bld_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
			valid_s1     <= 1'b0;
			fwd_valid_q  <= 1'b0;
			fwd_idx_q    <= '0;
			fwd_data_q   <= '0;
			total_q      <= '0;
			promo_q      <= '0;
		end else begin
			if (clr_active_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == '1) clr_active_q <= 1'b0;
			end
			valid_s1 <= item_pop;
			if (bld_wr) begin
				fwd_valid_q <= 1'b1;
				fwd_idx_q   <= idx_s1;
				fwd_data_q  <= bld_data;
			end
			if (valid_s1) begin
				total_q <= total_nxt;
				promo_q <= promo_nxt;
			end
		end
	end

	assign res_valid = valid_s1;
	always_comb begin
		res.total = total_nxt;
		res.promo = promo_nxt;
		res.hit   = hit;
	end

endmodule
`default_nettype wire

// File: hdl/promo_revenue_join_aggregate.sv
`default_nettype none
// -----------------------------------------------------------------------------
// promo_revenue_join_aggregate: promo revenue hash-join and aggregate
// Part records build a direct-indexed table; lineitem records probe it and
// add discounted revenue to a total and a promo total.
// -----------------------------------------------------------------------------
// Queue-style block: push a record while full is low, pop results while empty
// is low. Every record gives exactly one result: the running total and promo
// sums after that record, plus hit (build: key newly stored; probe: record
// counted). After reset the part table (2^KEY_BITS entries) is wiped one entry
// per cycle, and full stays high until the wipe is done; config writes are
// taken at any time. Once running, one record is taken per cycle while full is
// low. A result passes through the middle queue, the table read register and the
// result queue before it shows on the result ports. Throughput is set by the
// one-read, one-write table: each record does one read and at most one write
// in the back end, with the last write forwarded to the following record. The
// front end parses the date and forms price * (100 - discount) as records
// arrive; a small queue separates it from the table stage, and a result queue
// with credit flow control lets pop stall without losing anything. Sums
// saturate at 2^56-1.
// -----------------------------------------------------------------------------
module promo_revenue_join_aggregate #(
	parameter int unsigned KEY_BITS  = prja_pkg::KEY_BITS_DEF,
	parameter int unsigned MID_DEPTH = prja_pkg::MID_DEPTH_DEF,
	parameter int unsigned OUT_DEPTH = prja_pkg::OUT_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// record request side
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic                               kind,
	input  wire logic [prja_pkg::KEY_IN_W-1:0]      part_key,
	input  wire logic [prja_pkg::PREFIX_W-1:0]      type_prefix,
	input  wire logic [prja_pkg::TEXT_W-1:0]        ship_date_text,
	input  wire logic [prja_pkg::PRICE_W-1:0]       price_cents,
	input  wire logic [prja_pkg::DISC_W-1:0]        discount_pct,
	// result side
	output logic                                    empty,
	input  wire logic                               pop,
	output logic      [prja_pkg::SUM_W-1:0]         total_sum,
	output logic      [prja_pkg::SUM_W-1:0]         promo_sum,
	output logic                                    hit,
	// config writes
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [prja_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [prja_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import prja_pkg::*;

	localparam int unsigned MID_W     = $bits(item_t) + KEY_BITS;
	localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH+1);

	item_t                 f_item;
	logic [KEY_BITS-1:0]   f_idx;
	logic [MID_W-1:0]      mid_rdata;
	logic                  mid_empty, mid_full, mid_push;
	item_t                 b_item;
	logic [KEY_BITS-1:0]   b_idx;
	logic                  b_pop, clearing;
	logic                  res_valid;
	res_t                  res_in, res_out;
	logic                  out_full;
	logic [OUT_CNT_W-1:0]  out_count;

	// no records while the table wipe runs
	assign full     = mid_full | clearing;
	assign mid_push = push & ~full;

	prja_front #(
		.KEY_BITS (KEY_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.kind           (kind),
		.part_key       (part_key),
		.type_prefix    (type_prefix),
		.ship_date_text (ship_date_text),
		.price_cents    (price_cents),
		.discount_pct   (discount_pct),
		.item           (f_item),
		.idx            (f_idx)
	);

	// classified records waiting for the table
	prja_queue #(
		.WIDTH (MID_W),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  ({f_item, f_idx}),
		.pop    (b_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty),
		.full   (mid_full),
		.count  ()
	);

	assign b_item = item_t'(mid_rdata[MID_W-1:KEY_BITS]);
	assign b_idx  = mid_rdata[KEY_BITS-1:0];

	prja_back #(
		.KEY_BITS  (KEY_BITS),
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (~mid_empty),
		.item       (b_item),
		.idx        (b_idx),
		.item_pop   (b_pop),
		.out_count  (out_count),
		.res_valid  (res_valid),
		.res        (res_in),
		.clearing   (clearing)
	);

	// results waiting for pop; back end never pushes past its credit
	prja_queue #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.wdata  (res_in),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty),
		.full   (out_full),
		.count  (out_count)
	);

	assign total_sum = res_out.total;
	assign promo_sum = res_out.promo;
	assign hit       = res_out.hit;

	// credit flow must keep the result queue from overflowing
	a_no_out_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_full)
		else $error("result pushed into full result queue");

	// the table stage stays idle during the wipe
	a_no_issue_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !b_pop)
		else $error("table access during clear pass");

	// nothing can have been queued while the wipe ran
	a_mid_empty_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing) |-> mid_empty)
		else $error("record queued during clear pass");

	// every record issued to the table stage gives a result in the next cycle
	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		b_pop |=> res_valid)
		else $error("issued record produced no result");

endmodule
`default_nettype wire
